### rtl/polygon_convexity_check_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the polygon convexity checker
// Concurrent checks on a clock with a synchronous active-low reset; the
// bodies drop out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef POLYGON_CONVEXITY_CHECK_ASSERT_SVH
`define POLYGON_CONVEXITY_CHECK_ASSERT_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define PCC_ASSERT(lbl, c, r, p) \
  lbl: assert property (@(posedge c) disable iff (!r) p) else $error("pcc check failed");
// Expression must never be true outside reset
`define PCC_ASSERT_NEVER(lbl, c, r, e) \
  lbl: assert property (@(posedge c) disable iff (!r) !(e)) else $error("pcc check failed");
`else
`define PCC_ASSERT(lbl, c, r, p)
`define PCC_ASSERT_NEVER(lbl, c, r, e)
`endif

`endif

### rtl/pcc_pkg.sv
// ---------------------------------------------------------------------------
// Polygon convexity checker package
// Widths, queue sizes and the job record passed from front to back.
// ---------------------------------------------------------------------------
package pcc_pkg;

  // Coordinate width (signed Q12.4 at 16 bits)
  localparam int COORD_BITS = 16;
  // Difference of two coordinates, product of two differences, cross product
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CROSS_W    = PROD_W + 1;

  // Triples evaluated per vertex: the running one plus two wrap-round ones
  localparam int TRIPLE_N   = 3;
  localparam int TRI_RUN    = 0;
  localparam int TRI_WRAP_A = 1;
  localparam int TRI_WRAP_B = 2;

  // Job queue between front and back (depth a power of two)
  localparam int MQ_DEPTH   = 4;
  localparam int MQ_AW      = $clog2(MQ_DEPTH);
  localparam int MQ_CW      = $clog2(MQ_DEPTH + 1);

  // Result queue
  localparam int OQ_DEPTH   = 2;
  localparam int OQ_AW      = $clog2(OQ_DEPTH);
  localparam int OQ_CW      = $clog2(OQ_DEPTH + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [CROSS_W-1:0]    cross_t;

  // Cross product (A-B)x(C-B) = ba_x*bc_y - ba_y*bc_x
  typedef struct packed {
    diff_t ba_x;
    diff_t bc_y;
    diff_t ba_y;
    diff_t bc_x;
  } triple_t;

  typedef struct packed {
    logic                            last;
    logic [TRIPLE_N-1:0]             tri_valid;
    triple_t [TRIPLE_N-1:0]          trips;
  } job_t;

endpackage

### rtl/polygon_convexity_check.sv
// ---------------------------------------------------------------------------
// Polygon convexity checker
// Streaming cross-product sign test over the vertices of a closed polygon.
//
//   channel  ports                                          handshake
//   input    in_vertex_x, in_vertex_y, in_last_vertex       push / full
//   result   out_is_convex                                  empty / pop
//
// One vertex per cycle is taken while full is low. After the last vertex is
// taken, its verdict passes the job queue, the product stage and the result
// queue. The job queue holds four jobs and the result queue two verdicts, so
// the front keeps taking vertices while results wait to be popped.
// Reset is synchronous; no clearing pass follows.
// ---------------------------------------------------------------------------
module polygon_convexity_check (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  pcc_pkg::coord_t  in_vertex_x,
  input  pcc_pkg::coord_t  in_vertex_y,
  input  logic             in_last_vertex,
  output logic             empty,
  input  logic             pop,
  output logic             out_is_convex
);

  logic           accept;
  logic           job_push;
  pcc_pkg::job_t  job;
  logic           head_valid, head_pop;
  pcc_pkg::job_t  head_job;

  assign accept = push && !full;

  // Front: hold vertices, form differences
  pcc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .vertex_x    (in_vertex_x),
    .vertex_y    (in_vertex_y),
    .last_vertex (in_last_vertex),
    .job_push    (job_push),
    .job         (job)
  );

  // Decouple front and back
  pcc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_job   (job),
    .full       (full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Back: products, signs, verdict
  pcc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .head_pop   (head_pop),
    .empty      (empty),
    .pop        (pop),
    .is_convex  (out_is_convex)
  );

endmodule

### rtl/pcc_front.sv
// ---------------------------------------------------------------------------
// Polygon convexity checker front end
// Holds the first two and the two most recent vertices, forms coordinate
// differences for every triple a vertex closes and hands them on as a job.
// ---------------------------------------------------------------------------
module pcc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  pcc_pkg::coord_t     vertex_x,
  input  pcc_pkg::coord_t     vertex_y,
  input  logic                last_vertex,
  output logic                job_push,
  output pcc_pkg::job_t       job
);

  pcc_pkg::coord_t first_x_r, first_y_r, second_x_r, second_y_r;
  pcc_pkg::coord_t older_x_r, older_y_r, newer_x_r, newer_y_r;
  logic [1:0]      seen_cnt_r, seen_cnt_nxt;
  logic            enough;

  assign enough = (seen_cnt_r >= 2'd2);

  // Difference of two coordinates, exact
  function automatic pcc_pkg::diff_t sub(input pcc_pkg::coord_t a, input pcc_pkg::coord_t b);
    return pcc_pkg::DIFF_W'(a) - pcc_pkg::DIFF_W'(b);
  endfunction

  function automatic pcc_pkg::triple_t make_triple(
    input pcc_pkg::coord_t ax, input pcc_pkg::coord_t ay,
    input pcc_pkg::coord_t bx, input pcc_pkg::coord_t by,
    input pcc_pkg::coord_t cx, input pcc_pkg::coord_t cy);
    pcc_pkg::triple_t t;
    t.ba_x = sub(ax, bx);
    t.bc_y = sub(cy, by);
    t.ba_y = sub(ay, by);
    t.bc_x = sub(cx, bx);
    return t;
  endfunction

  // Build the job: running triple, then the two that close the polygon
  always_comb begin
    job.last = last_vertex;
    job.tri_valid[pcc_pkg::TRI_RUN]    = enough;
    job.tri_valid[pcc_pkg::TRI_WRAP_A] = enough && last_vertex;
    job.tri_valid[pcc_pkg::TRI_WRAP_B] = enough && last_vertex;
    job.trips[pcc_pkg::TRI_RUN] =
      make_triple(older_x_r, older_y_r, newer_x_r, newer_y_r, vertex_x, vertex_y);
    job.trips[pcc_pkg::TRI_WRAP_A] =
      make_triple(newer_x_r, newer_y_r, vertex_x, vertex_y, first_x_r, first_y_r);
    job.trips[pcc_pkg::TRI_WRAP_B] =
      make_triple(vertex_x, vertex_y, first_x_r, first_y_r, second_x_r, second_y_r);
  end

  // Only jobs that carry a triple or close a polygon go to the back
  assign job_push = accept && (enough || last_vertex);

  // Advance the vertex count, saturating at three, clear on the last vertex
  always_comb begin
    seen_cnt_nxt = seen_cnt_r;
    if (accept) begin
      if (last_vertex) begin
        seen_cnt_nxt = 2'd0;
      end else if (seen_cnt_r != 2'd3) begin
        seen_cnt_nxt = seen_cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_cnt_r <= 2'd0;
    end else begin
      seen_cnt_r <= seen_cnt_nxt;
    end
  end

  // Hold the vertices; each is written before it is read
  always_ff @(posedge clk) begin
    if (accept) begin
      if (seen_cnt_r == 2'd0) begin
        first_x_r <= vertex_x;
        first_y_r <= vertex_y;
      end
      if (seen_cnt_r == 2'd1) begin
        second_x_r <= vertex_x;
        second_y_r <= vertex_y;
      end
      older_x_r <= newer_x_r;
      older_y_r <= newer_y_r;
      newer_x_r <= vertex_x;
      newer_y_r <= vertex_y;
    end
  end

endmodule

### rtl/pcc_queue.sv
// ---------------------------------------------------------------------------
// Polygon convexity checker job queue
// Short first-in first-out store of jobs between front and back.
// ---------------------------------------------------------------------------
`include "polygon_convexity_check_assert.svh"

module pcc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pcc_pkg::job_t   push_job,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output pcc_pkg::job_t   head_job
);

  pcc_pkg::job_t                 store_r [pcc_pkg::MQ_DEPTH];
  logic [pcc_pkg::MQ_AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [pcc_pkg::MQ_CW-1:0]     cnt_r, cnt_nxt;

  assign full       = (cnt_r == pcc_pkg::MQ_CW'(pcc_pkg::MQ_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = store_r[rd_ptr_r];

  assign cnt_nxt = cnt_r + pcc_pkg::MQ_CW'(push) - pcc_pkg::MQ_CW'(pop);

  // Advance pointers and count; pointers wrap as the depth is a power of two
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Write the incoming job
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_job;
    end
  end

  `PCC_ASSERT(a_mq_bound, clk, rst_n, cnt_r <= pcc_pkg::MQ_CW'(pcc_pkg::MQ_DEPTH))
  `PCC_ASSERT_NEVER(a_mq_pop_empty, clk, rst_n, pop && (cnt_r == '0))
  `PCC_ASSERT(a_mq_grow, clk, rst_n, (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))

endmodule

### rtl/pcc_back.sv
// ---------------------------------------------------------------------------
// Polygon convexity checker back end
// Multiplies the differences of up to three triples, takes the sign of each
// cross product, gathers the signs of one polygon and queues the verdict.
// ---------------------------------------------------------------------------
`include "polygon_convexity_check_assert.svh"

module pcc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  pcc_pkg::job_t   head_job,
  output logic            head_pop,
  output logic            empty,
  input  logic            pop,
  output logic            is_convex
);

  // Product stage
  logic                          s1_valid_r;
  logic                          s1_last_r;
  logic [pcc_pkg::TRIPLE_N-1:0]  s1_tv_r;
  pcc_pkg::prod_t                s1_p_r [pcc_pkg::TRIPLE_N];
  pcc_pkg::prod_t                s1_q_r [pcc_pkg::TRIPLE_N];
  logic                          s1_go, s1_load;

  // Sign gathering
  logic                          seen_neg_r, seen_pos_r;
  logic                          neg_all, pos_all;
  logic [pcc_pkg::TRIPLE_N-1:0]  neg_v, pos_v;
  pcc_pkg::cross_t               cross_v [pcc_pkg::TRIPLE_N];

  // Result queue
  logic                          oq_data_r [pcc_pkg::OQ_DEPTH];
  logic [pcc_pkg::OQ_AW-1:0]     oq_wr_r, oq_rd_r;
  logic [pcc_pkg::OQ_CW-1:0]     oq_cnt_r;
  logic                          oq_full, oq_push, oq_pop;

  assign oq_full = (oq_cnt_r == pcc_pkg::OQ_CW'(pcc_pkg::OQ_DEPTH));
  assign s1_go   = !(s1_last_r && oq_full);
  assign s1_load = !s1_valid_r || s1_go;
  assign head_pop = head_valid && s1_load;

  // Multiply: one register after each product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_last_r <= head_job.last;
      s1_tv_r   <= head_job.tri_valid;
      for (int i = 0; i < pcc_pkg::TRIPLE_N; i++) begin
        s1_p_r[i] <= pcc_pkg::PROD_W'(head_job.trips[i].ba_x)
                   * pcc_pkg::PROD_W'(head_job.trips[i].bc_y);
        s1_q_r[i] <= pcc_pkg::PROD_W'(head_job.trips[i].ba_y)
                   * pcc_pkg::PROD_W'(head_job.trips[i].bc_x);
      end
    end
  end

  // Subtract and classify the sign of each cross product; drop zeros
  always_comb begin
    for (int i = 0; i < pcc_pkg::TRIPLE_N; i++) begin
      cross_v[i] = pcc_pkg::CROSS_W'(s1_p_r[i]) - pcc_pkg::CROSS_W'(s1_q_r[i]);
      neg_v[i]   = s1_tv_r[i] && cross_v[i][pcc_pkg::CROSS_W-1];
      pos_v[i]   = s1_tv_r[i] && !cross_v[i][pcc_pkg::CROSS_W-1] && (cross_v[i] != '0);
    end
    neg_all = seen_neg_r || (|neg_v);
    pos_all = seen_pos_r || (|pos_v);
  end

  // Gather signs; clear once the polygon is closed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_neg_r <= 1'b0;
      seen_pos_r <= 1'b0;
    end else if (s1_valid_r && s1_go) begin
      if (s1_last_r) begin
        seen_neg_r <= 1'b0;
        seen_pos_r <= 1'b0;
      end else begin
        seen_neg_r <= neg_all;
        seen_pos_r <= pos_all;
      end
    end
  end

  // Result queue: verdict in, oldest verdict out
  assign oq_push   = s1_valid_r && s1_go && s1_last_r;
  assign empty     = (oq_cnt_r == '0);
  assign oq_pop    = pop && !empty;
  assign is_convex = oq_data_r[oq_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_r <= oq_wr_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + 1'b1;
      end
      oq_cnt_r <= oq_cnt_r + pcc_pkg::OQ_CW'(oq_push) - pcc_pkg::OQ_CW'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_data_r[oq_wr_r] <= !(neg_all && pos_all);
    end
  end

  `PCC_ASSERT(a_oq_bound, clk, rst_n, oq_cnt_r <= pcc_pkg::OQ_CW'(pcc_pkg::OQ_DEPTH))
  `PCC_ASSERT(a_flags_clear, clk, rst_n, oq_push |=> (!seen_neg_r && !seen_pos_r))
  `PCC_ASSERT(a_s1_hold, clk, rst_n, (s1_valid_r && !s1_go) |=> (s1_valid_r && $stable(s1_last_r)))

endmodule

### test/polygon_convexity_check_test.sv
// ---------------------------------------------------------------------------
// Polygon convexity checker testbench
// Streams polygons into the vertex queue and checks every verdict popped
// from the result queue against a local cross-product tracker. A short
// table of hand-picked outlines comes first. Random outlines follow:
// convex curves, dented curves, scatters and tiny polygons. These run
// through phases of sender idling and receiver stalling.
// ---------------------------------------------------------------------------
module polygon_convexity_check_test;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 1550;
  localparam int PHASE_N       = 4;
  localparam int SETTLE_CYCLES = 8;
  localparam int COORD_MIN     = -32768;
  localparam int COORD_MAX     = 32767;

  typedef struct {
    int x;
    int y;
    bit last;
    bit typed;
    bit verdict;
  } vertex_row_t;

  logic            clk            = 1'b0;
  logic            rst_n          = 1'b0;
  logic            push           = 1'b0;
  pcc_pkg::coord_t in_vertex_x    = '0;
  pcc_pkg::coord_t in_vertex_y    = '0;
  logic            in_last_vertex = 1'b0;
  logic            pop            = 1'b0;
  logic            full;
  logic            empty;
  logic            out_is_convex;

  // Tracker state: first two corners, last two corners, turn directions
  pcc_pkg::coord_t first_x = '0, first_y = '0, second_x = '0, second_y = '0;
  pcc_pkg::coord_t older_x = '0, older_y = '0, newer_x = '0, newer_y = '0;
  int unsigned     corner_count = 0;
  bit              saw_cw = 1'b0, saw_ccw = 1'b0;

  bit verdicts_due[$];
  int outline_x[$];
  int outline_y[$];
  int fail_count     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;
  int vertices_sent  = 0;

  int idle_plan  [PHASE_N] = '{0, 83, 0, 24};
  int stall_plan [PHASE_N] = '{0, 0, 83, 24};

  // Hand-picked outlines; verdicts typed in where they are obvious
  vertex_row_t directed_rows [21] = '{
    // lone vertex at the most negative corner
    '{-32768, -32768, 1'b1, 1'b1, 1'b1},
    // two opposite extremes
    '{ 32767,  32767, 1'b0, 1'b0, 1'b0},
    '{-32768, -32768, 1'b1, 1'b1, 1'b1},
    // triangle spanning the full range
    '{-32768, -32768, 1'b0, 1'b0, 1'b0},
    '{ 32767, -32768, 1'b0, 1'b0, 1'b0},
    '{ 32767,  32767, 1'b1, 1'b1, 1'b1},
    // three points on one line
    '{     0,      0, 1'b0, 1'b0, 1'b0},
    '{    16,     16, 1'b0, 1'b0, 1'b0},
    '{    32,     32, 1'b1, 1'b1, 1'b1},
    // dented quadrilateral
    '{     0,      0, 1'b0, 1'b0, 1'b0},
    '{  1600,      0, 1'b0, 1'b0, 1'b0},
    '{   160,    160, 1'b0, 1'b0, 1'b0},
    '{     0,   1600, 1'b1, 1'b0, 1'b0},
    // clockwise square on the extremes
    '{-32768,  32767, 1'b0, 1'b0, 1'b0},
    '{ 32767,  32767, 1'b0, 1'b0, 1'b0},
    '{ 32767, -32768, 1'b0, 1'b0, 1'b0},
    '{-32768, -32768, 1'b1, 1'b1, 1'b1},
    // self-crossing bow tie
    '{     0,      0, 1'b0, 1'b0, 1'b0},
    '{   160,    160, 1'b0, 1'b0, 1'b0},
    '{   160,      0, 1'b0, 1'b0, 1'b0},
    '{     0,    160, 1'b1, 1'b0, 1'b0}
  };

  polygon_convexity_check dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_vertex_x    (in_vertex_x),
    .in_vertex_y    (in_vertex_y),
    .in_last_vertex (in_last_vertex),
    .empty          (empty),
    .pop            (pop),
    .out_is_convex  (out_is_convex)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fail_count++;
  endtask

  // Note the turn direction at corner B of A-B-C, exactly
  function automatic void record_turn(
    pcc_pkg::coord_t ax, pcc_pkg::coord_t ay,
    pcc_pkg::coord_t bx, pcc_pkg::coord_t by,
    pcc_pkg::coord_t cx, pcc_pkg::coord_t cy);
    longint turn_z;
    turn_z = (longint'(ax) - longint'(bx)) * (longint'(cy) - longint'(by))
           - (longint'(ay) - longint'(by)) * (longint'(cx) - longint'(bx));
    if (turn_z < 0) begin
      saw_cw = 1'b1;
    end else if (turn_z > 0) begin
      saw_ccw = 1'b1;
    end
  endfunction

  // Advance the tracker by one vertex; returns the verdict on the last one
  function automatic bit take_vertex(pcc_pkg::coord_t vx, pcc_pkg::coord_t vy, bit last);
    bit enough;
    bit verdict;
    enough  = corner_count >= 2;
    verdict = 1'b1;
    if (corner_count == 0) begin
      first_x = vx;
      first_y = vy;
    end else if (corner_count == 1) begin
      second_x = vx;
      second_y = vy;
    end
    if (enough) begin
      record_turn(older_x, older_y, newer_x, newer_y, vx, vy);
    end
    if (last) begin
      // close the outline with the two wrap-round corners, then clear
      if (enough) begin
        record_turn(newer_x, newer_y, vx, vy, first_x, first_y);
        record_turn(vx, vy, first_x, first_y, second_x, second_y);
      end
      verdict = !(saw_cw && saw_ccw);
      first_x = '0; first_y = '0; second_x = '0; second_y = '0;
      older_x = '0; older_y = '0; newer_x = '0; newer_y = '0;
      corner_count = 0;
      saw_cw  = 1'b0;
      saw_ccw = 1'b0;
    end else begin
      older_x = newer_x;
      older_y = newer_y;
      newer_x = vx;
      newer_y = vy;
      if (corner_count < 3) begin
        corner_count++;
      end
    end
    return verdict;
  endfunction

  // Offer one vertex, hold it until the transfer, then predict
  task automatic send_vertex(int x, int y, bit last, bit typed, bit verdict);
    bit predicted;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push           <= 1'b1;
    in_vertex_x    <= pcc_pkg::coord_t'(x);
    in_vertex_y    <= pcc_pkg::coord_t'(y);
    in_last_vertex <= last;
    @(posedge clk);
    while (full) begin
      @(posedge clk);
    end
    predicted = take_vertex(pcc_pkg::coord_t'(x), pcc_pkg::coord_t'(y), last);
    if (last) begin
      verdicts_due = {verdicts_due, (typed ? verdict : predicted)};
    end
    vertices_sent++;
  endtask

  task automatic send_outline();
    foreach (outline_x[i]) begin
      send_vertex(outline_x[i], outline_y[i], i == outline_x.size() - 1, 1'b0, 1'b0);
    end
  endtask

  // Points on a parabola in x order: a convex outline once closed
  task automatic build_curve(int n);
    int step_x, bend, base_x, base_y;
    outline_x.delete();
    outline_y.delete();
    step_x = 1 + int'($urandom_range(20000 / (n - 1) - 1));
    bend   = int'($urandom_range(22000 / ((n - 1) * (n - 1))));
    base_x = int'($urandom_range(65535 - (n - 1) * step_x)) + COORD_MIN;
    base_y = int'($urandom_range(65535 - bend * (n - 1) * (n - 1))) + COORD_MIN;
    for (int k = 0; k < n; k++) begin
      outline_x = {outline_x, base_x + k * step_x};
      outline_y = {outline_y, base_y + bend * k * k};
    end
  endtask

  // Random points in [-span, span-1] on both axes
  task automatic build_scatter(int n, int span);
    outline_x.delete();
    outline_y.delete();
    repeat (n) begin
      outline_x = {outline_x, int'($urandom_range(2 * span - 1)) - span};
      outline_y = {outline_y, int'($urandom_range(2 * span - 1)) - span};
    end
  endtask

  function automatic int fit_coord(int v);
    return (v < COORD_MIN) ? COORD_MIN : (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  // Rotate the start, reverse the winding and mirror axes at random
  task automatic reshape_outline();
    repeat ($urandom_range(outline_x.size() - 1)) begin
      outline_x = {outline_x[1:$], outline_x[0]};
      outline_y = {outline_y[1:$], outline_y[0]};
    end
    if ($urandom_range(1)) begin
      outline_x.reverse();
      outline_y.reverse();
    end
    if ($urandom_range(1)) begin
      foreach (outline_x[i]) outline_x[i] = -outline_x[i] - 1;
    end
    if ($urandom_range(1)) begin
      foreach (outline_y[i]) outline_y[i] = -outline_y[i] - 1;
    end
  endtask

  // Result side: stall at random, pop when asked
  always @(negedge clk) begin
    pop <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each popped verdict with the oldest one due
  always @(posedge clk) begin : check_verdict
    bit want;
    if (rst_n && pop && !empty) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch($sformatf("verdict %0b popped with none due", out_is_convex));
      end else begin
        want = verdicts_due.pop_front();
        if (out_is_convex !== want) begin
          report_mismatch($sformatf("is_convex %0b, expected %0b", out_is_convex, want));
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int kind;
    int idx;
    int phase_target;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_vertex(directed_rows[i].x, directed_rows[i].y, directed_rows[i].last,
                  directed_rows[i].typed, directed_rows[i].verdict);
    end

    for (int p = 0; p < PHASE_N; p++) begin
      send_idle_pct  = idle_plan[p];
      recv_stall_pct = stall_plan[p];
      phase_target   = vertices_sent + RANDOM_ITEMS / PHASE_N;
      while (vertices_sent < phase_target) begin
        kind = int'($urandom_range(99));
        if (kind < 8) begin
          // one or two vertices: always convex
          build_scatter(int'($urandom_range(2, 1)), 32768);
        end else if (kind < 50) begin
          build_curve(int'($urandom_range(12, 3)));
        end else if (kind < 55) begin
          // long outline keeps the vertex count saturated
          build_curve(int'($urandom_range(40, 20)));
        end else if (kind < 70) begin
          // dent one corner of a convex curve
          build_curve(int'($urandom_range(10, 3)));
          idx = int'($urandom_range(outline_x.size() - 1));
          outline_x[idx] = fit_coord(outline_x[idx] + int'($urandom_range(4000)) - 2000);
          outline_y[idx] = fit_coord(outline_y[idx] + int'($urandom_range(4000)) - 2000);
        end else if (kind < 85) begin
          build_scatter(int'($urandom_range(10, 3)), 32768);
        end else begin
          // tiny grid: repeats and collinear runs
          build_scatter(int'($urandom_range(8, 3)), 3);
        end
        reshape_outline();
        send_outline();
      end
    end

    @(negedge clk);
    push <= 1'b0;

    // Drain the result queue, then let the pipeline settle
    while (verdicts_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
